// ===== sv/hpt_pkg.sv =====
package hpt_pkg;

  // default configuration
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // fixed field widths
  localparam int IN_W  = 32;
  localparam int MAT_W = 32;
  localparam int MAT_N = 16;

  typedef enum logic [2:0] {
    ACT_LOAD_FWD   = 3'd0,
    ACT_LOAD_INV   = 3'd1,
    ACT_FWD_POINT  = 3'd2,
    ACT_FWD_VECTOR = 3'd3,
    ACT_FWD_NORMAL = 3'd4,
    ACT_INV_POINT  = 3'd5,
    ACT_INV_VECTOR = 3'd6,
    ACT_INV_NORMAL = 3'd7
  } action_t;

  // per-request flags that ride along the divider pipeline
  typedef struct packed {
    logic       pt;    // point request (else vector or normal)
    logic       zdiv;  // homogeneous term was zero
    logic [2:0] neg;   // quotient is negative, per lane
    logic [2:0] nz;    // numerator is nonzero, per lane
    logic [2:0] ovf;   // quotient far beyond the output range, per lane
  } side_t;

endpackage

// ===== sv/homogeneous_point_transform.sv =====
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   action, entry_index, entry_value, coord_x/y/z
// out_      output     out_valid/out_stall out_x/y/z, zero_divisor, saturated
//
// One request per cycle sustained while in_stall is low; the restoring divider computes
// one quotient bit per stage over COORD_WIDTH + 1 stages.
// Load requests write the matrix at acceptance and give no result.
// Reset (synchronous, active low) empties the pipeline and sets both matrices to identity.
// A skid register behind the last stage takes one result under out_stall; in_stall
// rises only while that skid register is full, and the whole pipeline holds with it.
module homogeneous_point_transform import hpt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_action,
  input  logic [3:0]                    in_entry_index,
  input  logic signed [MAT_W-1:0]       in_entry_value,
  input  logic signed [IN_W-1:0]        in_coord_x,
  input  logic signed [IN_W-1:0]        in_coord_y,
  input  logic signed [IN_W-1:0]        in_coord_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          out_zero_divisor,
  output logic                          out_saturated
);

  localparam int PW   = 2 * IN_W;            // product width
  localparam int MW   = PW + 1;              // magnitude of a row sum
  localparam int SW   = MW + 1;              // signed row sum
  localparam int DW   = MW;                  // divisor and remainder
  localparam int NW   = MW + FRAC_BITS;      // dividend
  localparam int QW   = COORD_WIDTH + 1;     // quotient bits computed
  localparam int VW   = QW + 2;              // signed rounded quotient
  localparam int XW   = SW + COORD_WIDTH + 3;
  localparam int NST  = QW + 7;

  localparam logic [63:0]            ONE_WIDE = 64'd1 << FRAC_BITS;
  localparam logic signed [MAT_W-1:0] COEF_ONE = ONE_WIDE[MAT_W-1:0];
  localparam logic [SW-1:0]          ONE_S    = {{(SW-1){1'b0}}, 1'b1};
  localparam logic signed [SW-1:0]   HALF     = ONE_S << (FRAC_BITS - 1);
  localparam logic [XW-1:0]          ONE_X    = {{(XW-1){1'b0}}, 1'b1};
  localparam logic signed [XW-1:0]   MAXV     = (ONE_X << (COORD_WIDTH - 1)) - ONE_X;
  localparam logic signed [XW-1:0]   MINV     = ~MAXV;

  // matrices
  logic signed [MAT_W-1:0] fwd_r [MAT_N];
  logic signed [MAT_W-1:0] inv_r [MAT_N];

  // control
  logic [NST-1:0] vld_r;
  logic           sk_full_r;
  logic           en, acc;

  // stage A: coefficients and operand
  logic signed [MAT_W-1:0] a_coef_r [MAT_N];
  logic signed [IN_W-1:0]  a_c_r    [3];
  logic                    a_pt_r;
  // stage B: products
  logic signed [PW-1:0]    b_prod_r [MAT_N];
  logic                    b_pt_r;
  // stage C: row sums
  logic signed [SW-1:0]    c_sum_r  [4];
  logic                    c_pt_r;
  // divider pipeline, index 0 is the setup stage
  logic [DW-1:0]           dv_rem_r [QW+1][3];
  logic [QW-1:0]           dv_q_r   [QW+1][3];
  logic [DW-1:0]           dv_den_r [QW+1];
  logic signed [SW-1:0]    dv_vec_r [QW+1][3];
  side_t                   dv_side_r[QW+1];
  // stage D (dividend prep)
  logic [NW-1:0]           d_num_r  [3];
  logic [DW-1:0]           d_den_r;
  logic signed [SW-1:0]    d_vec_r  [3];
  side_t                   d_side_r;
  // round stage
  logic signed [VW-1:0]    rn_val_r [3];
  logic signed [SW-1:0]    rn_vec_r [3];
  side_t                   rn_side_r;
  // output stage and skid
  logic signed [COORD_WIDTH-1:0] o_x_r [3];
  logic                          o_zd_r, o_sat_r;
  logic signed [COORD_WIDTH-1:0] sk_x_r [3];
  logic                          sk_zd_r, sk_sat_r;

  // next values
  logic signed [MAT_W-1:0] coef_nxt [MAT_N];
  logic signed [PW-1:0]    prod_nxt [MAT_N];
  logic signed [SW-1:0]    sum_nxt  [4];
  logic [NW-1:0]           num_nxt  [3];
  logic [DW-1:0]           den_nxt;
  logic signed [SW-1:0]    vec_nxt  [3];
  side_t                   dside_nxt;
  logic [DW-1:0]           rem_nxt  [QW+1][3];
  logic [QW-1:0]           q_nxt    [QW+1][3];
  side_t                   eside_nxt;
  logic signed [VW-1:0]    val_nxt  [3];
  logic signed [COORD_WIDTH-1:0] ox_nxt [3];
  logic                    osat_nxt;

  // request decode
  action_t act;
  logic    is_load, is_pt, is_vec, is_nrm, is_fwd;

  assign act = action_t'(in_action);

  always_comb begin
    is_load = 1'b0;
    is_pt   = 1'b0;
    is_vec  = 1'b0;
    is_nrm  = 1'b0;
    unique case (act) inside
      ACT_LOAD_FWD, ACT_LOAD_INV:     is_load = 1'b1;
      ACT_FWD_POINT, ACT_INV_POINT:   is_pt   = 1'b1;
      ACT_FWD_VECTOR, ACT_INV_VECTOR: is_vec  = 1'b1;
      default:                        is_nrm  = 1'b1;
    endcase
  end

  assign is_fwd = (act == ACT_FWD_POINT) || (act == ACT_FWD_VECTOR) ||
                  (act == ACT_FWD_NORMAL);

  // handshake: the pipeline moves unless the skid register is occupied
  assign en       = ~sk_full_r;
  assign in_stall = sk_full_r;
  assign acc      = in_valid & ~sk_full_r;

  // coefficient selection; normals take the transpose of the other matrix
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        if (is_nrm) begin
          coef_nxt[i*4+k] = (i < 3 && k < 3) ? (is_fwd ? inv_r[k*4+i] : fwd_r[k*4+i])
                                             : '0;
        end else if (is_vec) begin
          coef_nxt[i*4+k] = (i < 3 && k < 3) ? (is_fwd ? fwd_r[i*4+k] : inv_r[i*4+k])
                                             : '0;
        end else begin
          coef_nxt[i*4+k] = is_fwd ? fwd_r[i*4+k] : inv_r[i*4+k];
        end
      end
    end
  end

  // products; the w column multiplies by one, a shift
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 3; k++) begin
        prod_nxt[i*4+k] = a_coef_r[i*4+k] * a_c_r[k];
      end
      prod_nxt[i*4+3] = PW'(a_coef_r[i*4+3]) <<< FRAC_BITS;
    end
  end

  // row sums, with the rounding half for vectors and normals
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum_nxt[i] = SW'(b_prod_r[i*4]) + SW'(b_prod_r[i*4+1]) + SW'(b_prod_r[i*4+2]) +
                   SW'(b_prod_r[i*4+3]) + (b_pt_r ? '0 : HALF);
    end
  end

  // magnitudes and signs for the divider
  always_comb begin
    logic [SW-1:0] t;
    logic [SW-1:0] td;
    td               = c_sum_r[3][SW-1] ? -c_sum_r[3] : c_sum_r[3];
    den_nxt          = td[DW-1:0];
    dside_nxt        = '0;
    dside_nxt.pt     = c_pt_r;
    dside_nxt.zdiv   = (c_sum_r[3] == '0);
    for (int l = 0; l < 3; l++) begin
      t                = c_sum_r[l][SW-1] ? -c_sum_r[l] : c_sum_r[l];
      num_nxt[l]       = {t[MW-1:0], {FRAC_BITS{1'b0}}};
      dside_nxt.neg[l] = c_sum_r[l][SW-1] ^ c_sum_r[3][SW-1];
      dside_nxt.nz[l]  = (c_sum_r[l] != '0);
      vec_nxt[l]       = c_sum_r[l] >>> FRAC_BITS;
    end
  end

  // divider: setup with overflow check and leading partial remainder,
  // then restoring steps, one quotient bit each
  always_comb begin
    logic [NW-1:0] hi;
    logic [DW:0]   r2;
    eside_nxt = d_side_r;
    for (int l = 0; l < 3; l++) begin
      hi                = d_num_r[l] >> QW;
      eside_nxt.ovf[l]  = (hi >= NW'(d_den_r));
      rem_nxt[0][l]     = hi[DW-1:0];
      q_nxt[0][l]       = d_num_r[l][QW-1:0];
    end
    for (int j = 0; j < QW; j++) begin
      for (int l = 0; l < 3; l++) begin
        r2 = {dv_rem_r[j][l], dv_q_r[j][l][QW-1]};
        if (r2 >= {1'b0, dv_den_r[j]}) begin
          r2               = r2 - {1'b0, dv_den_r[j]};
          q_nxt[j+1][l]    = {dv_q_r[j][l][QW-2:0], 1'b1};
        end else begin
          q_nxt[j+1][l]    = {dv_q_r[j][l][QW-2:0], 1'b0};
        end
        rem_nxt[j+1][l] = r2[DW-1:0];
      end
    end
  end

  // round half away from zero and apply sign
  always_comb begin
    logic [QW:0] qr;
    for (int l = 0; l < 3; l++) begin
      qr = {1'b0, dv_q_r[QW][l]} +
           (({dv_rem_r[QW][l], 1'b0} >= {1'b0, dv_den_r[QW]}) ? {{QW{1'b0}}, 1'b1} : '0);
      val_nxt[l] = dv_side_r[QW].neg[l] ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
    end
  end

  // saturation to the output range
  always_comb begin
    logic signed [XW-1:0] x;
    osat_nxt = 1'b0;
    for (int l = 0; l < 3; l++) begin
      if (rn_side_r.pt) begin
        x = {{(XW-VW){rn_val_r[l][VW-1]}}, rn_val_r[l]};
      end else begin
        x = {{(XW-SW){rn_vec_r[l][SW-1]}}, rn_vec_r[l]};
      end
      if (rn_side_r.pt && rn_side_r.zdiv && !rn_side_r.nz[l]) begin
        ox_nxt[l] = '0;
      end else if (rn_side_r.pt && (rn_side_r.zdiv || rn_side_r.ovf[l])) begin
        ox_nxt[l] = rn_side_r.neg[l] ? MINV[COORD_WIDTH-1:0] : MAXV[COORD_WIDTH-1:0];
        osat_nxt  = 1'b1;
      end else if (x > MAXV) begin
        ox_nxt[l] = MAXV[COORD_WIDTH-1:0];
        osat_nxt  = 1'b1;
      end else if (x < MINV) begin
        ox_nxt[l] = MINV[COORD_WIDTH-1:0];
        osat_nxt  = 1'b1;
      end else begin
        ox_nxt[l] = x[COORD_WIDTH-1:0];
      end
    end
  end

  // control registers and matrices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      sk_full_r <= 1'b0;
      for (int i = 0; i < MAT_N; i++) begin
        fwd_r[i] <= (i % 5 == 0) ? COEF_ONE : '0;
        inv_r[i] <= (i % 5 == 0) ? COEF_ONE : '0;
      end
    end else begin
      if (en) begin
        vld_r <= {vld_r[NST-2:0], acc & ~is_load};
      end
      if (sk_full_r) begin
        if (!out_stall) sk_full_r <= 1'b0;
      end else if (vld_r[NST-1] && out_stall) begin
        sk_full_r <= 1'b1;
      end
      if (acc && act == ACT_LOAD_FWD) fwd_r[in_entry_index] <= in_entry_value;
      if (acc && act == ACT_LOAD_INV) inv_r[in_entry_index] <= in_entry_value;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      a_coef_r <= coef_nxt;
      a_c_r[0] <= in_coord_x;
      a_c_r[1] <= in_coord_y;
      a_c_r[2] <= in_coord_z;
      a_pt_r   <= is_pt;
      b_prod_r <= prod_nxt;
      b_pt_r   <= a_pt_r;
      c_sum_r  <= sum_nxt;
      c_pt_r   <= b_pt_r;
      d_num_r  <= num_nxt;
      d_den_r  <= den_nxt;
      d_vec_r  <= vec_nxt;
      d_side_r <= dside_nxt;
      dv_rem_r[0]  <= rem_nxt[0];
      dv_q_r[0]    <= q_nxt[0];
      dv_den_r[0]  <= d_den_r;
      dv_vec_r[0]  <= d_vec_r;
      dv_side_r[0] <= eside_nxt;
      for (int j = 1; j <= QW; j++) begin
        dv_rem_r[j]  <= rem_nxt[j];
        dv_q_r[j]    <= q_nxt[j];
        dv_den_r[j]  <= dv_den_r[j-1];
        dv_vec_r[j]  <= dv_vec_r[j-1];
        dv_side_r[j] <= dv_side_r[j-1];
      end
      rn_val_r  <= val_nxt;
      rn_vec_r  <= dv_vec_r[QW];
      rn_side_r <= dv_side_r[QW];
      o_x_r     <= ox_nxt;
      o_zd_r    <= rn_side_r.pt & rn_side_r.zdiv;
      o_sat_r   <= osat_nxt;
    end
    if (!sk_full_r && vld_r[NST-1] && out_stall) begin
      sk_x_r   <= o_x_r;
      sk_zd_r  <= o_zd_r;
      sk_sat_r <= o_sat_r;
    end
  end

  // result port: the skid register holds the older result
  assign out_valid        = sk_full_r | vld_r[NST-1];
  assign out_x            = sk_full_r ? sk_x_r[0] : o_x_r[0];
  assign out_y            = sk_full_r ? sk_x_r[1] : o_x_r[1];
  assign out_z            = sk_full_r ? sk_x_r[2] : o_x_r[2];
  assign out_zero_divisor = sk_full_r ? sk_zd_r : o_zd_r;
  assign out_saturated    = sk_full_r ? sk_sat_r : o_sat_r;

endmodule

// ===== sv/hpt_checker.sv =====
module hpt_checker import hpt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [COORD_WIDTH-1:0] out_x,
  input logic signed [COORD_WIDTH-1:0] out_y,
  input logic signed [COORD_WIDTH-1:0] out_z,
  input logic                          out_zero_divisor,
  input logic                          out_saturated
);

  localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y) &&
                               $stable(out_z) && $stable(out_saturated))
    else $error("stalled result changed");

  // a stalled request stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("stalled request withdrawn");

  // input is held back only while a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result pending");

  // reset empties the result side
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

  // zero divisor gives a zero or clamped x coordinate; a clamped one raises saturated
  a_zdiv_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_divisor && out_x != '0 |->
      out_saturated && (out_x == CMAX || out_x == CMIN))
    else $error("zero divisor result not clamped");

endmodule

bind homogeneous_point_transform hpt_checker #(.COORD_WIDTH(COORD_WIDTH)) u_hpt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_x            (out_x),
  .out_y            (out_y),
  .out_z            (out_z),
  .out_zero_divisor (out_zero_divisor),
  .out_saturated    (out_saturated)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import hpt_pkg::*;

  localparam int FRAC       = FRAC_BITS_DEF;
  localparam int CW         = COORD_WIDTH_DEF;
  localparam int LATENCY    = CW + 8;
  localparam int N_RANDOM   = 1400;
  localparam int TAIL_ITEMS = 150;
  localparam int HOLD_AT    = 500;
  localparam int HOLD_LEN   = 300;
  localparam int STUCK_MAX  = 5000;

  typedef struct {
    action_t            action;
    logic [3:0]         index;
    logic signed [31:0] value;
    logic signed [31:0] x, y, z;
  } request_t;

  typedef struct {
    logic signed [CW-1:0] x, y, z;
    logic                 zdiv, sat;
  } coords_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_action = '0;
  logic [3:0] in_entry_index = '0;
  logic signed [31:0] in_entry_value = '0;
  logic signed [31:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CW-1:0] out_x, out_y, out_z;
  logic out_zero_divisor, out_saturated;

  request_t pending_q[$];
  coords_t  expected_q[$];
  logic signed [31:0] fwd_mat[16];
  logic signed [31:0] inv_mat[16];
  int errors = 0;
  int accepted_in = 0;
  int stuck_cycles = 0;
  bit stim_done = 1'b0;
  bit in_fire = 1'b0;

  homogeneous_point_transform i_dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic signed [127:0] coef(bit inv, int row, int col);
    return inv ? inv_mat[row*4 + col] : fwd_mat[row*4 + col];
  endfunction

  // clamp to the output range, flagging any clamp
  function automatic logic signed [CW-1:0] clamp(logic signed [127:0] v, inout logic sat);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (CW - 1)) - 1;
    lo = -(128'sd1 <<< (CW - 1));
    if (v > hi) begin
      sat = 1'b1;
      return hi[CW-1:0];
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  // expected coordinates of one transform request
  function automatic coords_t transform_coords(request_t rq);
    coords_t res;
    logic signed [127:0] c[4], s[4], o[3], den, num, q, r, acc;
    bit use_inv, normal;
    res.zdiv = 1'b0;
    res.sat = 1'b0;
    c[0] = rq.x;
    c[1] = rq.y;
    c[2] = rq.z;
    c[3] = 128'sd1 <<< FRAC;
    use_inv = rq.action >= ACT_INV_POINT;
    if (rq.action == ACT_FWD_POINT || rq.action == ACT_INV_POINT) begin
      for (int i = 0; i < 4; i++) begin
        s[i] = 0;
        for (int k = 0; k < 4; k++) s[i] += coef(use_inv, i, k) * c[k];
      end
      den = s[3] < 0 ? -s[3] : s[3];
      res.zdiv = (den == 0);
      for (int i = 0; i < 3; i++) begin
        if (den == 0) begin
          o[i] = s[i] == 0 ? 128'sd0 : (s[i] < 0 ? -(128'sd1 <<< 64) : (128'sd1 <<< 64));
        end else begin
          num = (s[i] < 0 ? -s[i] : s[i]) <<< FRAC;
          q = num / den;
          r = num % den;
          if ((r <<< 1) >= den) q += 1;
          if ((s[i] < 0) != (s[3] < 0)) q = -q;
          o[i] = q;
        end
      end
    end else begin
      // normals use the transpose of the other matrix
      normal = (rq.action == ACT_FWD_NORMAL || rq.action == ACT_INV_NORMAL);
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int k = 0; k < 3; k++)
          acc += (normal ? coef(!use_inv, k, i) : coef(use_inv, i, k)) * c[k];
        acc += 128'sd1 <<< (FRAC - 1);
        o[i] = acc >>> FRAC;
      end
    end
    res.x = clamp(o[0], res.sat);
    res.y = clamp(o[1], res.sat);
    res.z = clamp(o[2], res.sat);
    return res;
  endfunction

  // request side accept, matrix update and result check
  always @(posedge clk) begin
    request_t rq;
    coords_t want;
    in_fire = rst_n && in_valid && !in_stall;
    if (in_fire) begin
      rq = pending_q.pop_front();
      accepted_in++;
      if (rq.action == ACT_LOAD_FWD) fwd_mat[rq.index] = rq.value;
      else if (rq.action == ACT_LOAD_INV) inv_mat[rq.index] = rq.value;
      else expected_q.push_back(transform_coords(rq));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", 64'(out_x), 64'd0);
      end else begin
        want = expected_q.pop_front();
        if (out_x !== want.x) report("out_x", 64'(out_x), 64'(want.x));
        if (out_y !== want.y) report("out_y", 64'(out_y), 64'(want.y));
        if (out_z !== want.z) report("out_z", 64'(out_z), 64'(want.z));
        if (out_zero_divisor !== want.zdiv)
          report("zero_divisor", 64'(out_zero_divisor), 64'(want.zdiv));
        if (out_saturated !== want.sat)
          report("saturated", 64'(out_saturated), 64'(want.sat));
      end
    end
  end

  // sender: idle bursts except near the end; a request waits until taken
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (in_gap > 0) in_gap--;
      else if (pending_q.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0)
        in_gap = $urandom_range(1, 5);
      if (in_gap == 0 && pending_q.size() > 0) begin
        in_valid <= 1'b1;
        in_action <= pending_q[0].action;
        in_entry_index <= pending_q[0].index;
        in_entry_value <= pending_q[0].value;
        in_coord_x <= pending_q[0].x;
        in_coord_y <= pending_q[0].y;
        in_coord_z <= pending_q[0].z;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall bursts plus one long hold to back up the pipeline
  int out_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    if (!hold_done && accepted_in >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) hold_left--;
    else if (out_gap > 0) out_gap--;
    else if (pending_q.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
      out_gap = $urandom_range(1, 5);
    out_stall <= (hold_left > 0) || (out_gap > 0);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_MAX) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      2: return $signed($urandom) >>> $urandom_range(8, 14);
      3: case ($urandom_range(0, 4))
           0: return 32'sh8000_0000;
           1: return 32'sh7fff_ffff;
           2: return 32'sh0001_0000;
           3: return -32'sh0001_0000;
           default: return 0;
         endcase
      default: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
    endcase
  endfunction

  function automatic request_t mk_load(bit inv, int idx, logic signed [31:0] v);
    request_t rq;
    rq.action = inv ? ACT_LOAD_INV : ACT_LOAD_FWD;
    rq.index = idx[3:0];
    rq.value = v;
    rq.x = $urandom;
    rq.y = $urandom;
    rq.z = $urandom;
    return rq;
  endfunction

  function automatic request_t mk_xform(action_t a, logic signed [31:0] x, y, z);
    request_t rq;
    rq.action = a;
    rq.index = 4'($urandom);
    rq.value = $urandom;
    rq.x = x;
    rq.y = y;
    rq.z = z;
    return rq;
  endfunction

  initial begin
    int n;
    for (int i = 0; i < 16; i++) begin
      fwd_mat[i] = (i % 5 == 0) ? 32'sh0001_0000 : 0;
      inv_mat[i] = fwd_mat[i];
    end

    // directed: identity on all six transforms, extremes of coordinates
    for (int a = ACT_FWD_POINT; a <= ACT_INV_NORMAL; a++)
      pending_q.push_back(mk_xform(action_t'(a), 32'sh8000_0000, 32'sh7fff_ffff, 32'sh0003_8000));
    pending_q.push_back(mk_xform(ACT_FWD_VECTOR, -1, 1, 0));
    // large coefficients drive saturation
    pending_q.push_back(mk_load(0, 0, 32'sh7fff_ffff));
    pending_q.push_back(mk_load(1, 5, 32'sh8000_0000));
    pending_q.push_back(mk_xform(ACT_FWD_VECTOR, 32'sh7fff_ffff, 1, 1));
    pending_q.push_back(mk_xform(ACT_INV_NORMAL, 1, 32'sh7fff_ffff, 1));
    pending_q.push_back(mk_xform(ACT_FWD_POINT, 32'sh4000_0000, 0, 0));
    // zero homogeneous term: forward row 3 cleared
    pending_q.push_back(mk_load(0, 15, 0));
    pending_q.push_back(mk_xform(ACT_FWD_POINT, 32'sh0001_0000, -32'sh0001_0000, 0));
    // homogeneous term halved, negative
    pending_q.push_back(mk_load(0, 15, -32'sh0000_8000));
    pending_q.push_back(mk_xform(ACT_FWD_POINT, 32'sh0000_0003, -32'sh0002_0001, 32'sh0000_0001));
    pending_q.push_back(mk_load(1, 14, 32'sh0000_0001));
    pending_q.push_back(mk_xform(ACT_INV_POINT, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000));

    // random: load bursts followed by transform runs
    n = 0;
    while (n < N_RANDOM) begin
      int loads;
      bit inv;
      inv = $urandom_range(0, 1);
      if ($urandom_range(0, 9) == 0) begin
        // clear a homogeneous row to hit the zero divisor
        for (int c = 12; c < 16; c++) pending_q.push_back(mk_load(inv, c, 0));
        n += 4;
      end else begin
        loads = $urandom_range(0, 6);
        for (int l = 0; l < loads; l++)
          pending_q.push_back(mk_load($urandom_range(0, 1), $urandom_range(0, 15), pick_value()));
        n += loads;
      end
      for (int t = $urandom_range(1, 10); t > 0; t--) begin
        pending_q.push_back(mk_xform(action_t'($urandom_range(ACT_FWD_POINT, ACT_INV_NORMAL)),
                                     pick_value(), pick_value(), pick_value()));
        n++;
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() == 0);
    wait (expected_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
